/* hdl/ccs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg - shared types and constants of the comment stripper
// Character codes, the result record and the queue entry that carries the
// one or two results raised by a single source byte.
// ----------------------------------------------------------------------------
package ccs_pkg;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h00;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef struct packed {
		logic       unterminated_comment;
		logic       end_of_text;
		logic [7:0] out_byte;
	} result_t;

	// first goes out before second; second is valid only when two is set
	typedef struct packed {
		logic    two;
		result_t first;
		result_t second;
	} entry_t;

endpackage

/* hdl/ccs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_front - scanner front end
// Accepts one source byte per cycle while the queue has room, tracks comment
// and quote context and pushes one queue entry per byte, save a held slash.
// ----------------------------------------------------------------------------
module ccs_front import ccs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       q_full,
	output logic       push,
	output entry_t     push_data
);

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_SLASH,
		MODE_LINE,
		MODE_BLOCK,
		MODE_BLOCK_STAR,
		MODE_QUOTE,
		MODE_QUOTE_ESC
	} mode_t;

	mode_t mode_q;
	logic  quote_single_q;

	mode_t   mode_d;
	logic    quote_single_d;
	logic    accept;
	logic    emit;
	entry_t  entry;

	// normal-text handling of the current byte, independent of the mode
	mode_t   nb_mode;
	logic    nb_single;
	logic    nb_emit;
	result_t nb_res;

	logic    line_end;
	result_t eot_res;
	result_t byte_res;
	result_t space_res;

	assign accept   = in_valid && !q_full;
	assign in_ready = !q_full;
	assign line_end = (in_byte == CH_LF) || (in_byte == CH_CR);

	always_comb begin
		byte_res  = '{unterminated_comment: 1'b0, end_of_text: 1'b0, out_byte: in_byte};
		space_res = '{unterminated_comment: 1'b0, end_of_text: 1'b0, out_byte: CH_SPACE};
		eot_res   = '{unterminated_comment: 1'b0, end_of_text: 1'b1, out_byte: CH_ZERO};

		nb_mode   = MODE_NORMAL;
		nb_single = quote_single_q;
		nb_emit   = 1'b1;
		nb_res    = byte_res;
		if (in_byte == CH_ZERO) begin
			nb_single = 1'b0;
			nb_res    = eot_res;
		end else if (in_byte == CH_SLASH) begin
			nb_mode = MODE_SLASH;
			nb_emit = 1'b0;
		end else if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE) begin
			nb_mode   = MODE_QUOTE;
			nb_single = (in_byte == CH_SQUOTE);
		end
	end

	always_comb begin
		mode_d         = mode_q;
		quote_single_d = quote_single_q;
		emit           = 1'b1;
		entry.two      = 1'b0;
		entry.first    = byte_res;
		entry.second   = nb_res;

		case (mode_q)
			MODE_SLASH: begin
				if (in_byte == CH_SLASH || in_byte == CH_STAR) begin
					entry.two    = 1'b1;
					entry.first  = space_res;
					entry.second = space_res;
					mode_d       = (in_byte == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
				end else begin
					// release the held slash, then treat the byte as normal text
					entry.first.out_byte = CH_SLASH;
					entry.two            = nb_emit;
					mode_d               = nb_mode;
					quote_single_d       = nb_single;
				end
			end
			MODE_LINE: begin
				if (in_byte == CH_ZERO) begin
					entry.first    = eot_res;
					mode_d         = MODE_NORMAL;
					quote_single_d = 1'b0;
				end else if (line_end) begin
					mode_d = MODE_NORMAL;
				end else begin
					entry.first = space_res;
				end
			end
			MODE_BLOCK, MODE_BLOCK_STAR: begin
				if (in_byte == CH_ZERO) begin
					entry.first                      = eot_res;
					entry.first.unterminated_comment = 1'b1;
					mode_d                           = MODE_NORMAL;
					quote_single_d                   = 1'b0;
				end else if (line_end) begin
					mode_d = MODE_BLOCK;
				end else begin
					entry.first = space_res;
					if (mode_q == MODE_BLOCK_STAR && in_byte == CH_SLASH)
						mode_d = MODE_NORMAL;
					else
						mode_d = (in_byte == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
				end
			end
			MODE_QUOTE: begin
				if (in_byte == CH_ZERO) begin
					entry.first    = eot_res;
					mode_d         = MODE_NORMAL;
					quote_single_d = 1'b0;
				end else if (in_byte == (quote_single_q ? CH_SQUOTE : CH_DQUOTE)) begin
					mode_d         = MODE_NORMAL;
					quote_single_d = 1'b0;
				end else if (in_byte == CH_BSLASH) begin
					mode_d = MODE_QUOTE_ESC;
				end
			end
			MODE_QUOTE_ESC: begin
				if (in_byte == CH_ZERO) begin
					entry.first    = eot_res;
					mode_d         = MODE_NORMAL;
					quote_single_d = 1'b0;
				end else begin
					mode_d = MODE_QUOTE;
				end
			end
			default: begin
				emit           = nb_emit;
				entry.first    = nb_res;
				mode_d         = nb_mode;
				quote_single_d = nb_single;
			end
		endcase
	end

	assign push      = accept && emit;
	assign push_data = entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_NORMAL;
			quote_single_q <= 1'b0;
		end else if (accept) begin
			mode_q         <= mode_d;
			quote_single_q <= quote_single_d;
		end
	end

endmodule

/* hdl/ccs_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_fifo - entry queue between scanner and output stage
// Small register queue, one push and one pop per cycle, head shown directly.
// ----------------------------------------------------------------------------
module ccs_fifo import ccs_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output entry_t pop_data,
	output logic   empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* hdl/ccs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_back - output stage
// Drains queue entries one result per transfer through an output register,
// holding the second result of a two-result entry in a side register.
// ----------------------------------------------------------------------------
module ccs_back import ccs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_empty,
	input  entry_t  q_data,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic    out_valid_q;
	result_t out_q;
	logic    second_pend_q;
	result_t second_q;
	logic    load;

	assign load      = !out_valid_q || out_ready;
	assign pop       = load && !second_pend_q && !q_empty;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (second_pend_q)
				out_q <= second_q;
			else
				out_q <= q_data.first;
		end
		if (pop)
			second_q <= q_data.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			second_pend_q <= 1'b0;
		end else if (load) begin
			if (second_pend_q) begin
				out_valid_q   <= 1'b1;
				second_pend_q <= 1'b0;
			end else begin
				out_valid_q   <= !q_empty;
				second_pend_q <= !q_empty && q_data.two;
			end
		end
	end

endmodule

/* hdl/c_comment_stripper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_comment_stripper - blank comments in a C-like byte stream
// Replaces comment bytes by spaces, keeps strings and line ends, length kept.
// ----------------------------------------------------------------------------
// Usage:
//   Source bytes enter on the slave stream (s_*), one byte per transfer; a
//   zero byte ends the text. Results leave on the master stream (m_*): the
//   byte or a space, m_tlast on the echoed zero, m_tuser on that zero when
//   the text ended inside a block comment.
//   A slash is held until the next byte shows whether a comment opens, so
//   that byte produces two results; every other byte produces one.
//   The scanner classifies an accepted byte and writes the entry queue at the
//   accepting edge; the output register takes the queue head when free, and
//   the result is then valid on m_*.
//   Throughput: one byte per cycle in while the queue is not full and one
//   result per cycle out while m_tready is high; the output register is the
//   limit, so a byte that releases a held slash takes a transfer per result.
//   Reset returns the scanner to normal text and empties the queue.
//   When m_tready is low the output register holds, the queue of FIFO_DEPTH
//   entries fills, and s_tready drops only once it is full.
// ----------------------------------------------------------------------------
module c_comment_stripper import ccs_pkg::*; #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // end_of_text
	output logic       m_tuser    // [0] unterminated_comment
);

	logic    q_full;
	logic    q_empty;
	logic    push;
	logic    pop;
	entry_t  push_data;
	entry_t  pop_data;
	result_t out_res;

	ccs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	ccs_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	ccs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = out_res.out_byte;
	assign m_tlast = out_res.end_of_text;
	assign m_tuser = out_res.unterminated_comment;

endmodule

/* hdl/ccs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_checker - port-level checks of the comment stripper
// Watches the output stream and the flags it carries.
// ----------------------------------------------------------------------------
module ccs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	// hold a stalled transfer
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("m_tvalid dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("output payload changed while stalled");

	// the unterminated flag rides only on the end marker
	a_flag_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("unterminated flag without end of text");

	// the end marker echoes the zero byte
	a_last_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata == 8'h00)
		else $error("end of text on a nonzero byte");

endmodule

bind c_comment_stripper ccs_checker u_ccs_checker (.*);
